>>> rtl/rotc_pkg.sv
// Package with the command codes, register indexes and shared structs of the relay timer block.
`timescale 1ns / 1ps

package rotc_pkg;

  // Command codes carried by an input item.
  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_TEST         = 3'd1,
    CMD_VALVE_OPEN   = 3'd2,
    CMD_VALVE_CLOSE  = 3'd3,
    CMD_THERMO_OPEN  = 3'd4,
    CMD_THERMO_CLOSE = 3'd5,
    CMD_PWM          = 3'd6,
    CMD_OFF          = 3'd7
  } command_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NORMALLY_OPEN     = 2'd0;
  localparam logic [1:0] CFG_VALVE_PULSE_TICKS = 2'd1;
  localparam logic [1:0] CFG_TEST_HALF_PERIOD  = 2'd2;

  // Register reset values.
  localparam logic [15:0] VALVE_PULSE_RESET = 16'd6000;
  localparam logic [15:0] TEST_HALF_RESET   = 16'd12000;

  // Configuration as seen by the timer core.
  typedef struct packed {
    logic        normally_open;
    logic [15:0] valve_pulse_ticks;
    logic [15:0] test_half_period_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic out_a;
    logic out_b;
    logic thermo_open_flag;
    logic save_request;
  } result_t;

  // Outcome of one pwm phase change.
  typedef struct packed {
    logic       on_phase;
    logic       level;
    logic [9:0] len;
  } pwm_step_t;

endpackage

>>> rtl/rotc_core.sv
// Timer core: relay levels, test, off and pwm timers, thermostat flag and their next-state logic.
`timescale 1ns / 1ps

module rotc_core #(
  parameter int PWM_PERIOD = 1000
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [2:0]       command,
  input  logic [9:0]       duty,
  input  rotc_pkg::cfg_t   cfg,
  output rotc_pkg::result_t result
);

  import rotc_pkg::*;

  localparam logic [9:0] PERIOD = 10'(PWM_PERIOD);

  // State registers.
  logic        level_a, level_a_next;
  logic        level_b, level_b_next;
  logic        test_running, test_running_next;
  logic [15:0] test_count, test_count_next;
  logic        off_pending, off_pending_next;
  logic [15:0] off_count, off_count_next;
  logic        pwm_running, pwm_running_next;
  logic        pwm_on, pwm_on_next;
  logic [9:0]  pwm_count, pwm_count_next;
  logic [9:0]  duty_level, duty_level_next;
  logic        thermo_flag, thermo_flag_next;
  logic        save;

  // One phase change: entering the on phase drives the open level unless the
  // duty is zero, entering the off phase drives the closed level unless the
  // duty fills the whole period.
  function automatic pwm_step_t pwm_flip(input logic on_in, input logic lvl_in,
                                         input logic [9:0] d, input logic nopen);
    pwm_step_t s;
    s.level = lvl_in;
    if (!on_in) begin
      s.on_phase = 1'b1;
      if (d != 10'd0) s.level = ~nopen;
      s.len = d;
    end else begin
      s.on_phase = 1'b0;
      if (d < PERIOD) s.level = nopen;
      s.len = PERIOD - d;
    end
    return s;
  endfunction

  // Phase change that skips a zero-length phase with a second change.
  function automatic pwm_step_t pwm_advance(input logic on_in, input logic lvl_in,
                                            input logic [9:0] d, input logic nopen);
    pwm_step_t s;
    s = pwm_flip(on_in, lvl_in, d, nopen);
    if (s.len == 10'd0) s = pwm_flip(s.on_phase, s.level, d, nopen);
    return s;
  endfunction

  // Next-state logic for one transfer.
  always_comb begin
    logic [16:0] cnt;
    logic [9:0]  duty_sat;
    pwm_step_t   ps;

    level_a_next      = level_a;
    level_b_next      = level_b;
    test_running_next = test_running;
    test_count_next   = test_count;
    off_pending_next  = off_pending;
    off_count_next    = off_count;
    pwm_running_next  = pwm_running;
    pwm_on_next       = pwm_on;
    pwm_count_next    = pwm_count;
    duty_level_next   = duty_level;
    thermo_flag_next  = thermo_flag;
    save              = 1'b0;
    cnt               = '0;
    duty_sat          = (duty > PERIOD) ? PERIOD : duty;
    ps                = '0;

    unique case (command_t'(command))
      CMD_TICK: begin
        // Expiries act in the order test, off, pwm.
        if (test_running) begin
          cnt = {1'b0, test_count} + 17'd1;
          if (cnt >= {1'b0, cfg.test_half_period_ticks}) begin
            level_a_next    = ~level_a_next;
            level_b_next    = ~level_b_next;
            test_count_next = '0;
          end else begin
            test_count_next = cnt[15:0];
          end
        end
        if (off_pending) begin
          cnt = {1'b0, off_count} + 17'd1;
          if (cnt >= {1'b0, cfg.valve_pulse_ticks}) begin
            level_a_next     = 1'b0;
            level_b_next     = 1'b0;
            off_pending_next = 1'b0;
            off_count_next   = '0;
          end else begin
            off_count_next = cnt[15:0];
          end
        end
        if (pwm_running) begin
          if (pwm_count <= 10'd1) begin
            ps             = pwm_advance(pwm_on, level_a_next, duty_level, cfg.normally_open);
            pwm_on_next    = ps.on_phase;
            level_a_next   = ps.level;
            pwm_count_next = ps.len;
          end else begin
            pwm_count_next = pwm_count - 10'd1;
          end
        end
      end
      CMD_TEST: begin
        level_a_next      = 1'b1;
        level_b_next      = 1'b0;
        test_running_next = 1'b1;
        test_count_next   = '0;
      end
      CMD_VALVE_OPEN: begin
        test_running_next = 1'b0;
        level_a_next      = 1'b1;
        level_b_next      = 1'b0;
        off_pending_next  = 1'b1;
        off_count_next    = '0;
      end
      CMD_VALVE_CLOSE: begin
        test_running_next = 1'b0;
        level_a_next      = 1'b0;
        level_b_next      = 1'b1;
        off_pending_next  = 1'b1;
        off_count_next    = '0;
      end
      CMD_THERMO_OPEN: begin
        level_a_next = ~cfg.normally_open;
        if (!thermo_flag) begin
          thermo_flag_next = 1'b1;
          save             = 1'b1;
        end
      end
      CMD_THERMO_CLOSE: begin
        level_a_next = cfg.normally_open;
        if (thermo_flag) begin
          thermo_flag_next = 1'b0;
          save             = 1'b1;
        end
      end
      CMD_PWM: begin
        duty_level_next  = duty_sat;
        pwm_running_next = 1'b1;
        ps               = pwm_advance(pwm_on, level_a, duty_sat, cfg.normally_open);
        pwm_on_next      = ps.on_phase;
        level_a_next     = ps.level;
        pwm_count_next   = ps.len;
      end
      CMD_OFF: begin
        test_running_next = 1'b0;
        test_count_next   = '0;
        off_pending_next  = 1'b0;
        off_count_next    = '0;
        level_a_next      = 1'b0;
        level_b_next      = 1'b0;
      end
    endcase
  end

  // The result reflects the state after the update.
  assign result.out_a            = level_a_next;
  assign result.out_b            = level_b_next;
  assign result.thermo_open_flag = thermo_flag_next;
  assign result.save_request     = save;

  // State update on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_a      <= 1'b0;
      level_b      <= 1'b0;
      test_running <= 1'b0;
      test_count   <= '0;
      off_pending  <= 1'b0;
      off_count    <= '0;
      pwm_running  <= 1'b0;
      pwm_on       <= 1'b0;
      pwm_count    <= '0;
      duty_level   <= '0;
      thermo_flag  <= 1'b0;
    end else if (step) begin
      level_a      <= level_a_next;
      level_b      <= level_b_next;
      test_running <= test_running_next;
      test_count   <= test_count_next;
      off_pending  <= off_pending_next;
      off_count    <= off_count_next;
      pwm_running  <= pwm_running_next;
      pwm_on       <= pwm_on_next;
      pwm_count    <= pwm_count_next;
      duty_level   <= duty_level_next;
      thermo_flag  <= thermo_flag_next;
    end
  end

  // The stored duty never exceeds the period.
  a_duty_bounded: assert property (@(posedge clk) disable iff (rst)
    duty_level <= PERIOD)
    else $error("stored duty above the pwm period");

  // The pwm phase counter never exceeds the period while pwm runs.
  a_pwm_count_bounded: assert property (@(posedge clk) disable iff (rst)
    pwm_running |-> pwm_count <= PERIOD)
    else $error("pwm phase count above the period");

  // A valve command leaves exactly one output driven.
  a_valve_one_hot: assert property (@(posedge clk) disable iff (rst)
    step && (command == CMD_VALVE_OPEN || command == CMD_VALVE_CLOSE)
    |=> (level_a ^ level_b) && off_pending)
    else $error("valve command did not drive exactly one output");

endmodule

>>> rtl/relay_output_timer_controller.sv
// Top level of the relay output timer controller: handshakes, registers and result register.
`timescale 1ns / 1ps

//  Channel  Signals                                   Direction  Meaning
//  input    in_valid, in_ready, command, duty         in         tick or command item
//  output   out_valid, out_ready, out_a, out_b,       out        relay levels and thermostat
//           thermo_open_flag, save_request                        flag after each item
//  config   cfg_write, cfg_index, cfg_data            in         register write, no wait
//
//  One item is taken every cycle while no result waits; its result appears in the
//  output register on the next cycle, set by the single state update in the timer core.
//  Reset (rst, synchronous) clears all timers, levels and the output valid flag,
//  and loads the register defaults 0, 6000 and 12000.
//  While a result waits on out_ready, in_ready is low and the result holds;
//  a new item is taken in the same cycle that the waiting result transfers.

module relay_output_timer_controller #(
  parameter int PWM_PERIOD = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [9:0]  duty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_a,
  output logic        out_b,
  output logic        thermo_open_flag,
  output logic        save_request,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import rotc_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    in_xfer;

  // Input transfer whenever the output register is empty or being emptied.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normally_open          <= 1'b0;
      cfg.valve_pulse_ticks      <= VALVE_PULSE_RESET;
      cfg.test_half_period_ticks <= TEST_HALF_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_NORMALLY_OPEN)     cfg.normally_open          <= cfg_data[0];
      if (cfg_index == CFG_VALVE_PULSE_TICKS) cfg.valve_pulse_ticks      <= cfg_data;
      if (cfg_index == CFG_TEST_HALF_PERIOD)  cfg.test_half_period_ticks <= cfg_data;
    end
  end

  rotc_core #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (in_xfer),
    .command (command),
    .duty    (duty),
    .cfg     (cfg),
    .result  (result)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_a            <= result.out_a;
      out_b            <= result.out_b;
      thermo_open_flag <= result.thermo_open_flag;
      save_request     <= result.save_request;
    end
  end

  // A thermostat open command shows the flag set in its result.
  a_thermo_open: assert property (@(posedge clk) disable iff (rst)
    in_xfer && command == CMD_THERMO_OPEN |=> out_valid && thermo_open_flag)
    else $error("thermostat open did not set the flag");

  // A thermostat close command shows the flag cleared in its result.
  a_thermo_close: assert property (@(posedge clk) disable iff (rst)
    in_xfer && command == CMD_THERMO_CLOSE |=> out_valid && !thermo_open_flag)
    else $error("thermostat close did not clear the flag");

  // An off command clears both outputs.
  a_off_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && command == CMD_OFF |=> out_valid && !out_a && !out_b && !save_request)
    else $error("off command left an output driven");

  // A test command drives A high and B low.
  a_test_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && command == CMD_TEST |=> out_valid && out_a && !out_b)
    else $error("test command did not set the start levels");

endmodule
